/* design/fhvc_pkg.sv */
// Shared types and constants for the hash verdict cache.
// Used by fhvc_cell and fifo_hash_verdict_cache; no dependencies.
package fhvc_pkg;

  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned HASH_WORDS = 5;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned VERDICT_W  = 8;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  typedef struct packed {
    word_t    key_word0;
    word_t    key_word1;
    word_t    key_word2;
    word_t    key_word3;
    word_t    key_word4;
    verdict_t scan_verdict;
  } in_req_t;

  typedef struct packed {
    logic     hit;
    verdict_t verdict;
  } out_rsp_t;

  // Probe travelling down the cell chain: one ring slot per cycle.
  typedef struct packed {
    logic vld;
    idx_t addr;
    logic match;
  } probe_t;

  // Ring write, shared by all cells.
  typedef struct packed {
    logic en;
    idx_t addr;
  } wr_t;

endpackage

/* design/fhvc_cell.sv */
// One word-slice cell: holds one 32-bit word of every ring slot and
// folds its word compare into the probe it hands on. Depends on fhvc_pkg.
module fhvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fhvc_pkg::probe_t probe_i,
  input  fhvc_pkg::word_t  key_word_i,
  input  fhvc_pkg::wr_t    wr_i,
  input  fhvc_pkg::word_t  wr_word_i,
  output fhvc_pkg::probe_t probe_o
);

  fhvc_pkg::word_t  mem [fhvc_pkg::ENTRIES];
  fhvc_pkg::word_t  rd_word_q;
  fhvc_pkg::probe_t probe_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_word_i;
    end
    rd_word_q <= mem[probe_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_i;
    end
  end

  assign probe_o = '{vld:   probe_q.vld,
                     addr:  probe_q.addr,
                     match: probe_q.match && (rd_word_q == key_word_i)};

endmodule

/* design/fifo_hash_verdict_cache.sv */
// Top level of the hash verdict cache: request/response control, ring
// pointers and the chain of word-slice cells. Depends on fhvc_pkg, fhvc_cell.
//
// Cache of recently seen benign 160-bit hashes, kept as a FIFO ring of
// ENTRIES slots. Each request carries a hash (five 32-bit words) and the
// scanner's verdict. A hash found among the valid slots answers hit=1 with
// verdict 0 and leaves the ring alone; a miss passes the verdict through,
// and a benign miss (verdict 0) appends the hash, replacing the oldest slot
// once the ring is full. One request is worked on at a time. The ring is
// scanned one slot per cycle through a chain of five cells, each owning one
// hash word of every slot in its own memory with a registered read; once
// the last probe returns, a decide step answers and, on a benign miss,
// writes the ring. An empty ring skips the scan and goes straight to decide.
// A finished result sits in an output register, and the next request is
// accepted while it waits; only the decide step stalls on it.
// There is no clearing pass: slots are only read once written.
module fifo_hash_verdict_cache (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fhvc_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fhvc_pkg::out_rsp_t out_rsp_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StDecide = 2'd2;

  localparam int unsigned SUM_W = fhvc_pkg::CNT_W + 1;

  logic [1:0]          state_q, state_d;
  fhvc_pkg::in_req_t   req_q;
  fhvc_pkg::idx_t      oldest_q;        // slot of oldest valid entry
  fhvc_pkg::cnt_t      count_q;         // number of valid entries
  fhvc_pkg::idx_t      addr_q;          // next slot to probe
  fhvc_pkg::cnt_t      issue_left_q;    // probes still to launch
  fhvc_pkg::cnt_t      ret_left_q;      // probes still in flight or unlaunched
  logic                hit_q;
  logic                out_valid_q;
  fhvc_pkg::out_rsp_t  out_rsp_q;

  fhvc_pkg::probe_t    chain [fhvc_pkg::HASH_WORDS+1];
  fhvc_pkg::word_t     key_words [fhvc_pkg::HASH_WORDS];
  fhvc_pkg::wr_t       wr;
  fhvc_pkg::probe_t    res;

  logic                in_acc;
  logic                issue;
  logic                ring_full;
  logic                out_free;
  logic                decide;
  logic [SUM_W-1:0]    tail_sum;
  fhvc_pkg::idx_t      tail_slot;
  fhvc_pkg::idx_t      addr_nxt;
  fhvc_pkg::idx_t      oldest_nxt;

  assign key_words[0] = req_q.key_word0;
  assign key_words[1] = req_q.key_word1;
  assign key_words[2] = req_q.key_word2;
  assign key_words[3] = req_q.key_word3;
  assign key_words[4] = req_q.key_word4;

  // --- cell chain: probe enters cell 0 and picks up one word compare per cell
  assign issue    = (state_q == StSearch) && (issue_left_q != '0);
  assign chain[0] = '{vld: issue, addr: addr_q, match: 1'b1};

  for (genvar k = 0; k < fhvc_pkg::HASH_WORDS; k++) begin : g_cell
    fhvc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_i    (chain[k]),
      .key_word_i (key_words[k]),
      .wr_i       (wr),
      .wr_word_i  (key_words[k]),
      .probe_o    (chain[k+1])
    );
  end

  assign res = chain[fhvc_pkg::HASH_WORDS];

  // --- ring pointer arithmetic; oldest + count stays below 2*ENTRIES
  assign addr_nxt   = (addr_q == fhvc_pkg::IDX_W'(fhvc_pkg::ENTRIES - 1)) ?
                      '0 : addr_q + fhvc_pkg::IDX_W'(1);
  assign oldest_nxt = (oldest_q == fhvc_pkg::IDX_W'(fhvc_pkg::ENTRIES - 1)) ?
                      '0 : oldest_q + fhvc_pkg::IDX_W'(1);
  assign tail_sum   = SUM_W'(oldest_q) + SUM_W'(count_q);
  always_comb begin
    if (tail_sum >= SUM_W'(fhvc_pkg::ENTRIES)) begin
      tail_slot = fhvc_pkg::IDX_W'(tail_sum - SUM_W'(fhvc_pkg::ENTRIES));
    end else begin
      tail_slot = fhvc_pkg::IDX_W'(tail_sum);
    end
  end
  assign ring_full = (count_q == fhvc_pkg::CNT_W'(fhvc_pkg::ENTRIES));

  // --- handshakes
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign decide     = (state_q == StDecide) && out_free;

  // benign miss: full ring overwrites the oldest slot, else append at tail
  assign wr.en   = decide && !hit_q && (req_q.scan_verdict == '0);
  assign wr.addr = ring_full ? oldest_q : tail_slot;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = (count_q == '0) ? StDecide : StSearch;
        end
      end
      StSearch: begin
        if (res.vld && (ret_left_q == fhvc_pkg::CNT_W'(1))) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      oldest_q     <= '0;
      count_q      <= '0;
      addr_q       <= '0;
      issue_left_q <= '0;
      ret_left_q   <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        addr_q       <= oldest_q;
        issue_left_q <= count_q;
        ret_left_q   <= count_q;
        hit_q        <= 1'b0;
      end else begin
        if (issue) begin
          addr_q       <= addr_nxt;
          issue_left_q <= issue_left_q - fhvc_pkg::CNT_W'(1);
        end
        if (res.vld) begin
          ret_left_q <= ret_left_q - fhvc_pkg::CNT_W'(1);
          hit_q      <= hit_q || res.match;
        end
      end

      if (wr.en) begin
        if (ring_full) begin
          oldest_q <= oldest_nxt;
        end else begin
          count_q <= count_q + fhvc_pkg::CNT_W'(1);
        end
      end

      if (decide) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (decide) begin
      out_rsp_q.hit     <= hit_q;
      out_rsp_q.verdict <= hit_q ? '0 : req_q.scan_verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fhvc_pkg::CNT_W'(fhvc_pkg::ENTRIES))
    else $error("valid count exceeds ring size");

  a_oldest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= fhvc_pkg::IDX_W'(fhvc_pkg::ENTRIES - 1))
    else $error("oldest pointer out of range");

  a_no_stray_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StDecide) |-> !res.vld)
    else $error("probe returned outside of a search");

  a_inflight_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (ret_left_q >= issue_left_q))
    else $error("more probes returned than launched");

  a_no_write_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (!hit_q && state_q == StDecide))
    else $error("ring written on a hit or outside decide");
`endif

endmodule

/* dv/tb_fifo_hash_verdict_cache.sv */
// Self-checking testbench for fifo_hash_verdict_cache: directed and random
// tests against an in-bench ring predictor. Depends on fhvc_pkg, fifo_hash_verdict_cache.
module tb_fifo_hash_verdict_cache;
  import fhvc_pkg::*;

  localparam int unsigned HASH_BITS = HASH_WORDS * WORD_W;
  localparam int unsigned RANDOM_REQS = 560;

  typedef logic [HASH_BITS-1:0] hash_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     out_ready_i = 1'b0;
  in_req_t  in_req_i    = '0;
  logic     in_ready_o;
  logic     out_valid_o;
  out_rsp_t out_rsp_o;

  fifo_hash_verdict_cache DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Bench copy of the cache: ring of hashes, oldest slot, number of valid slots.
  hash_t ring_keys [ENTRIES];
  idx_t  ring_oldest = '0;
  cnt_t  ring_count  = '0;

  out_rsp_t    expected_rsps [$];  // one per accepted request, in order
  hash_t       sent_keys [$];      // every hash sent so far, for repeats
  out_rsp_t    oldest_rsp;
  int unsigned error_count = 0;
  int unsigned tx_idle_pct = 0;    // chance per cycle that the sender holds off
  int unsigned rx_idle_pct = 0;    // chance per cycle that the receiver stalls

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog. The limit leaves a wide margin over the slowest legal run
  // (every request at a full-ring scan plus stalls).
  initial begin
    #(12 * 6_000_000);
    $display("fifo_hash_verdict_cache: mismatch");
    $finish;
  end

  function automatic hash_t hash_of(input in_req_t r);
    return {r.key_word0, r.key_word1, r.key_word2, r.key_word3, r.key_word4};
  endfunction

  function automatic in_req_t make_req(input hash_t key, input verdict_t v);
    in_req_t r;
    r.key_word0    = key[4*WORD_W +: WORD_W];
    r.key_word1    = key[3*WORD_W +: WORD_W];
    r.key_word2    = key[2*WORD_W +: WORD_W];
    r.key_word3    = key[1*WORD_W +: WORD_W];
    r.key_word4    = key[0*WORD_W +: WORD_W];
    r.scan_verdict = v;
    return r;
  endfunction

  // Ring slot of the i-th valid entry, counted from the oldest.
  function automatic int unsigned ring_slot(input int unsigned i);
    return (int'(ring_oldest) + i) % ENTRIES;
  endfunction

  // Search oldest to newest; on a benign miss append, evicting the oldest
  // entry when the ring is full. Updates the bench state.
  function automatic out_rsp_t predict_lookup(input in_req_t r);
    hash_t       key;
    out_rsp_t    rsp;
    logic        found;
    int unsigned slot;
    key   = hash_of(r);
    found = 1'b0;
    for (int unsigned i = 0; i < ring_count; i++) begin
      if (ring_keys[ring_slot(i)] == key) begin
        found = 1'b1;
        break;
      end
    end
    if (found) begin
      rsp.hit     = 1'b1;
      rsp.verdict = '0;
      return rsp;
    end
    if (r.scan_verdict == '0) begin
      if (ring_count < ENTRIES) begin
        slot       = ring_slot(ring_count);
        ring_count = ring_count + 1'b1;
      end else begin
        slot        = ring_oldest;
        ring_oldest = idx_t'((slot + 1) % ENTRIES);
      end
      ring_keys[slot] = key;
    end
    rsp.hit     = 1'b0;
    rsp.verdict = r.scan_verdict;
    return rsp;
  endfunction

  function automatic hash_t random_hash();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Each word at one of its corner values.
  function automatic hash_t extreme_hash();
    hash_t key;
    for (int w = 0; w < HASH_WORDS; w++) begin
      case ($urandom_range(3))
        0:       key[w*WORD_W +: WORD_W] = '0;
        1:       key[w*WORD_W +: WORD_W] = '1;
        2:       key[w*WORD_W +: WORD_W] = 32'h8000_0000;
        default: key[w*WORD_W +: WORD_W] = 32'h0000_0001;
      endcase
    end
    return key;
  endfunction

  // Mix of hits on live entries, repeats of old hashes (some never stored),
  // one-bit near misses, corner keys and fresh keys.
  function automatic in_req_t pick_random_req();
    hash_t       key;
    verdict_t    v;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35 && ring_count != 0) begin
      key = ring_keys[ring_slot($urandom_range(int'(ring_count) - 1))];
    end else if (roll < 45 && sent_keys.size() != 0) begin
      key = sent_keys[$urandom_range(sent_keys.size() - 1)];
    end else if (roll < 55 && ring_count != 0) begin
      key = ring_keys[ring_slot($urandom_range(int'(ring_count) - 1))]
            ^ (hash_t'(1) << $urandom_range(HASH_BITS - 1));
    end else if (roll < 60) begin
      key = extreme_hash();
    end else begin
      key = random_hash();
    end
    roll = $urandom_range(99);
    if (roll < 55) v = '0;
    else if (roll < 60) v = '1;
    else v = verdict_t'($urandom_range(255, 1));
    return make_req(key, v);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Called and returns at a falling edge. Random hold-off first, then the
  // request is held until accepted; the prediction is taken at accept.
  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsps.push_back(predict_lookup(r));
    sent_keys.push_back(hash_of(r));
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every outstanding response is back.
  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_rsps.size() != 0);
  endtask

  // Receiver side: stall at random, decided at each falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Response checker: each accepted response against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        oldest_rsp = expected_rsps.pop_front();
        if (out_rsp_o.hit !== oldest_rsp.hit)
          report_mismatch($sformatf("hit got %b expected %b",
                                    out_rsp_o.hit, oldest_rsp.hit));
        if (out_rsp_o.verdict !== oldest_rsp.verdict)
          report_mismatch($sformatf("verdict got %0h expected %0h",
                                    out_rsp_o.verdict, oldest_rsp.verdict));
      end
    end
  end

  // Corner keys on a nearly empty ring: empty-ring lookup, hit after insert,
  // malicious miss not stored, verdict ignored on hit, one-bit neighbors,
  // hits on oldest and newest entries.
  task automatic test_directed_edges();
    hash_t alt_a;
    hash_t alt_b;
    alt_a = {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
    alt_b = ~alt_a;
    tx_idle_pct = 30;
    rx_idle_pct = 78;
    send_req(make_req('0, '0));                 // empty ring: miss, stored
    drain_responses();
    send_req(make_req('0, '0));                 // hit
    send_req(make_req('1, '1));                 // malicious miss, not stored
    send_req(make_req('1, '0));                 // still a miss, now stored
    send_req(make_req('1, 8'h7F));              // hit, verdict forced to 0
    send_req(make_req(hash_t'(1), '0));         // one bit off the zero key
    send_req(make_req(hash_t'(1) << (HASH_BITS - 1), 8'h80));
    send_req(make_req(alt_a, '0));
    send_req(make_req(alt_b, '0));
    send_req(make_req(alt_a, 8'h01));           // hit
    send_req(make_req('0, 8'h01));              // hit on oldest
    send_req(make_req(alt_b, 8'hFF));           // hit on newest
    drain_responses();
    send_req(make_req(hash_t'(1) << (HASH_BITS - 1), '0));  // earlier malicious key
    send_req(make_req(hash_t'(1) << (HASH_BITS - 1), 8'h10));
    for (int w = 0; w < HASH_WORDS; w++) begin
      // all-ones key with one word off by its low bit
      send_req(make_req(~(hash_t'(1) << (w * WORD_W)), verdict_t'(w + 1)));
    end
    send_req(make_req('1, '0));
  endtask

  // Random traffic in three idling phases, with a full drain between them.
  task automatic test_random_traffic();
    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        drain_responses();
        tx_idle_pct = 78;
        rx_idle_pct = 30;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        drain_responses();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_req(pick_random_req());
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_edges();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    // Room for one more full scan in case a stray response is on its way.
    repeat (int'(ring_count) + 16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("fifo_hash_verdict_cache: match");
    end else begin
      $display("fifo_hash_verdict_cache: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fhvc_pkg.sv
design/fhvc_cell.sv
design/fifo_hash_verdict_cache.sv
dv/tb_fifo_hash_verdict_cache.sv
